// ----- src/sc2a_pkg.sv -----
// Shared types, scan code constants and key lookup tables for the scan code decoder.
// No dependencies; imported by sc2a_decode and the top level.
package sc2a_pkg;

    localparam logic [7:0] PREFIX_EXT   = 8'hE0;
    localparam logic [7:0] RELEASE_MASK = 8'h80;
    localparam logic [6:0] CODE_MASK    = 7'h7F;
    localparam logic [6:0] CODE_LSHIFT  = 7'h2A;
    localparam logic [6:0] CODE_RSHIFT  = 7'h36;
    localparam logic [6:0] CODE_CTRL    = 7'h1D;
    localparam logic [6:0] CODE_ALT     = 7'h38;
    localparam logic [6:0] CODE_CAPS    = 7'h3A;
    localparam logic [7:0] EXT_UP       = 8'h48;
    localparam logic [7:0] EXT_DOWN     = 8'h50;
    localparam logic [7:0] EXT_LEFT     = 8'h4B;
    localparam logic [7:0] EXT_RIGHT    = 8'h4D;
    localparam logic [6:0] TABLE_LEN    = 7'd58;

    localparam logic       KIND_CHAR  = 1'b0;
    localparam logic       KIND_ARROW = 1'b1;

    localparam logic [1:0] ARROW_UP    = 2'd0;
    localparam logic [1:0] ARROW_DOWN  = 2'd1;
    localparam logic [1:0] ARROW_LEFT  = 2'd2;
    localparam logic [1:0] ARROW_RIGHT = 2'd3;

    localparam logic [6:0] ASCII_LOWER_A = 7'h61;
    localparam logic [6:0] ASCII_LOWER_Z = 7'h7A;
    localparam logic [6:0] ASCII_CASE    = 7'h20;

    typedef struct packed {
        logic       emit;
        logic       key_kind;
        logic [6:0] character;
        logic [1:0] arrow;
        logic       ctrl_down;
        logic       alt_down;
    } result_t;

    function automatic logic [6:0] plain_char(input logic [5:0] code);
        logic [6:0] ch;
        case (code)
            6'h01: ch = 7'h1B;
            6'h02: ch = 7'h31;
            6'h03: ch = 7'h32;
            6'h04: ch = 7'h33;
            6'h05: ch = 7'h34;
            6'h06: ch = 7'h35;
            6'h07: ch = 7'h36;
            6'h08: ch = 7'h37;
            6'h09: ch = 7'h38;
            6'h0A: ch = 7'h39;
            6'h0B: ch = 7'h30;
            6'h0C: ch = 7'h2D;
            6'h0D: ch = 7'h3D;
            6'h0E: ch = 7'h08;
            6'h0F: ch = 7'h09;
            6'h10: ch = 7'h71;
            6'h11: ch = 7'h77;
            6'h12: ch = 7'h65;
            6'h13: ch = 7'h72;
            6'h14: ch = 7'h74;
            6'h15: ch = 7'h79;
            6'h16: ch = 7'h75;
            6'h17: ch = 7'h69;
            6'h18: ch = 7'h6F;
            6'h19: ch = 7'h70;
            6'h1A: ch = 7'h5B;
            6'h1B: ch = 7'h5D;
            6'h1C: ch = 7'h0A;
            6'h1E: ch = 7'h61;
            6'h1F: ch = 7'h73;
            6'h20: ch = 7'h64;
            6'h21: ch = 7'h66;
            6'h22: ch = 7'h67;
            6'h23: ch = 7'h68;
            6'h24: ch = 7'h6A;
            6'h25: ch = 7'h6B;
            6'h26: ch = 7'h6C;
            6'h27: ch = 7'h3B;
            6'h28: ch = 7'h27;
            6'h29: ch = 7'h60;
            6'h2B: ch = 7'h5C;
            6'h2C: ch = 7'h7A;
            6'h2D: ch = 7'h78;
            6'h2E: ch = 7'h63;
            6'h2F: ch = 7'h76;
            6'h30: ch = 7'h62;
            6'h31: ch = 7'h6E;
            6'h32: ch = 7'h6D;
            6'h33: ch = 7'h2C;
            6'h34: ch = 7'h2E;
            6'h35: ch = 7'h2F;
            6'h39: ch = 7'h20;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [6:0] upper_char(input logic [5:0] code);
        logic [6:0] ch;
        case (code)
            6'h02: ch = 7'h21;
            6'h03: ch = 7'h40;
            6'h04: ch = 7'h23;
            6'h05: ch = 7'h24;
            6'h06: ch = 7'h25;
            6'h07: ch = 7'h5E;
            6'h08: ch = 7'h26;
            6'h09: ch = 7'h2A;
            6'h0A: ch = 7'h28;
            6'h0B: ch = 7'h29;
            6'h0C: ch = 7'h5F;
            6'h0D: ch = 7'h2B;
            6'h1A: ch = 7'h7B;
            6'h1B: ch = 7'h7D;
            6'h27: ch = 7'h3A;
            6'h28: ch = 7'h22;
            6'h29: ch = 7'h7E;
            6'h2B: ch = 7'h7C;
            6'h33: ch = 7'h3C;
            6'h34: ch = 7'h3E;
            6'h35: ch = 7'h3F;
            default: ch = plain_char(code);
        endcase
        return ch;
    endfunction

endpackage

// ----- src/sc2a_in_stage.sv -----
// Input register for scan code bytes with its valid/ready handshake.
// Depends on nothing but the clock and reset; feeds sc2a_decode.
module sc2a_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_scan_byte,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] scan_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_scan_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign scan_byte  = byte_reg;

endmodule

// ----- src/sc2a_decode.sv -----
// Modifier, caps lock and extended prefix flags plus the byte-to-result mapping.
// Uses sc2a_pkg for the constants, the lookup tables and result_t.
module sc2a_decode
    import sc2a_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] scan_byte,
    input  logic       advance,
    output result_t    result
);

    logic shift_reg, shift_next;
    logic ctrl_reg, ctrl_next;
    logic alt_reg, alt_next;
    logic caps_reg, caps_next;
    logic prefix_reg, prefix_next;

    logic       is_release;
    logic [6:0] code;
    logic [6:0] ch;
    logic [6:0] ch_case;

    assign is_release = (scan_byte & RELEASE_MASK) != 8'h00;
    assign code       = scan_byte[6:0] & CODE_MASK;
    assign ch         = shift_reg ? upper_char(code[5:0]) : plain_char(code[5:0]);
    assign ch_case    = ((shift_reg || caps_reg) && ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z)
                        ? ch - ASCII_CASE : ch;

    always_comb begin
        shift_next  = shift_reg;
        ctrl_next   = ctrl_reg;
        alt_next    = alt_reg;
        caps_next   = caps_reg;
        prefix_next = prefix_reg;
        result      = '0;
        result.ctrl_down = ctrl_reg;
        result.alt_down  = alt_reg;
        if (prefix_reg) begin
            prefix_next     = 1'b0;
            result.key_kind = KIND_ARROW;
            case (scan_byte)
                EXT_UP: begin
                    result.emit  = 1'b1;
                    result.arrow = ARROW_UP;
                end
                EXT_DOWN: begin
                    result.emit  = 1'b1;
                    result.arrow = ARROW_DOWN;
                end
                EXT_LEFT: begin
                    result.emit  = 1'b1;
                    result.arrow = ARROW_LEFT;
                end
                EXT_RIGHT: begin
                    result.emit  = 1'b1;
                    result.arrow = ARROW_RIGHT;
                end
                default: begin
                    result.emit = 1'b0;
                end
            endcase
        end else if (scan_byte == PREFIX_EXT) begin
            prefix_next = 1'b1;
        end else begin
            case (code)
                CODE_LSHIFT, CODE_RSHIFT: shift_next = !is_release;
                CODE_CTRL:                ctrl_next  = !is_release;
                CODE_ALT:                 alt_next   = !is_release;
                CODE_CAPS: begin
                    if (!is_release) begin
                        caps_next = !caps_reg;
                    end
                end
                default: begin
                    result.key_kind  = KIND_CHAR;
                    result.character = ch_case;
                    result.emit      = !is_release && code < TABLE_LEN && ch_case != 7'h00;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg  <= 1'b0;
            ctrl_reg   <= 1'b0;
            alt_reg    <= 1'b0;
            caps_reg   <= 1'b0;
            prefix_reg <= 1'b0;
        end else if (advance) begin
            shift_reg  <= shift_next;
            ctrl_reg   <= ctrl_next;
            alt_reg    <= alt_next;
            caps_reg   <= caps_next;
            prefix_reg <= prefix_next;
        end
    end

endmodule

// ----- src/scancode_to_ascii_decoder.sv -----
// Top level of the scan code set 1 to ASCII decoder: input stage, decode, result register.
// Depends on sc2a_pkg, sc2a_in_stage and sc2a_decode.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid / s_ready  s_scan_byte[7:0]
//   m_       out        m_valid / m_ready  m_key_kind, m_character[6:0], m_arrow[1:0],
//                                          m_ctrl_down, m_alt_down
//
// One byte per cycle while m_ is not stalled; a result reaches m_ from the input register via the result register.
// A byte moves from the input register through decode into the result register.
// Bytes that give no result still advance the flags and leave the result register alone.
// A stalled m_ side holds the result register and then the input register, then drops s_ready.
// Synchronous active-low reset clears all flags and both valid bits.
module scancode_to_ascii_decoder
    import sc2a_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_scan_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_key_kind,
    output logic [6:0] m_character,
    output logic [1:0] m_arrow,
    output logic       m_ctrl_down,
    output logic       m_alt_down
);

    logic       byte_valid;
    logic [7:0] scan_byte;
    logic       advance;
    result_t    result;
    result_t    out_reg;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign advance = byte_valid && (!out_valid_reg || m_ready);

    sc2a_in_stage u_in_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_scan_byte (s_scan_byte),
        .advance     (advance),
        .byte_valid  (byte_valid),
        .scan_byte   (scan_byte)
    );

    sc2a_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .scan_byte (scan_byte),
        .advance   (advance),
        .result    (result)
    );

    always_comb begin
        if (advance) begin
            out_valid_next = result.emit || (out_valid_reg && !m_ready);
        end else begin
            out_valid_next = out_valid_reg && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.emit) begin
            out_reg <= result;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_key_kind  = out_reg.key_kind;
    assign m_character = out_reg.character;
    assign m_arrow     = out_reg.arrow;
    assign m_ctrl_down = out_reg.ctrl_down;
    assign m_alt_down  = out_reg.alt_down;

endmodule
